>>> src/abad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abad_pkg: shared types and constants for the block average decision
// Field widths, the item kind code and the structs that pass between the
// top level and the window cells.
// ----------------------------------------------------------------------------
package abad_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 8;
    // Entry minus baseline.
    localparam int DIFF_W   = SAMPLE_W + 1;
    // Difference times gain, gain taken as a positive signed value.
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    // Five times the threshold, with a margin of four on either side.
    localparam int BOUND_W  = SAMPLE_W + 3;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

    // Query settings shared by every window cell.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] baseline;
        logic [GAIN_W-1:0]          gain;
        logic signed [BOUND_W-1:0]  bound;
        logic                       below;
    } query_t;

    // What one cell hands to the next one down the window.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] entry;
    } cell_link_t;

endpackage

>>> src/abad_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abad_cell: one entry of the decision window
// Holds one X average, shifts it on to the next cell when a block completes,
// and checks its entry against the query bound.
// ----------------------------------------------------------------------------
module abad_cell
    import abad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  cell_link_t link_in,
    output cell_link_t link_out,
    input  query_t     query,
    input  logic       pass_in,
    output logic       pass_out
);

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] entry_reg;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   bound_ext;
    logic                       pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= link_in.entry;
        end
    end

    // The scaled value is trunc(diff * 2 * gain / 10) = trunc(diff * gain / 5).
    // The bound has been moved to the product side, so no division is needed.
    assign diff      = DIFF_W'(entry_reg) - DIFF_W'(query.baseline);
    assign gain_s    = {1'b0, query.gain};
    assign prod      = PROD_W'(diff) * PROD_W'(gain_s);
    assign bound_ext = PROD_W'(query.bound);

    always_comb
    begin
        if (query.below)
        begin
            pass = (prod <= bound_ext);
        end
        else
        begin
            pass = (prod >= bound_ext);
        end
    end

    assign pass_out = pass_in & pass;
    assign link_out = '{valid: valid_reg, entry: entry_reg};

endmodule

>>> src/abad_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abad_axis: accumulator and block divider for one axis
// Sums the samples of a block, then divides the finished sum by the block
// length with a reciprocal multiply, truncating toward zero.
// ----------------------------------------------------------------------------
module abad_axis
    import abad_pkg::*;
#(
    parameter int BLOCK_LEN = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       acc_en,
    input  logic                       clear,
    input  logic                       load1,
    input  logic                       load2,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0] avg
);

    localparam int LEN_LOG = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 0;
    localparam int SUM_W   = SAMPLE_W + LEN_LOG;
    localparam int SHIFT   = SUM_W + LEN_LOG;
    localparam int RECIP_W = SUM_W + 2;
    localparam int MUL_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_total;
    logic signed [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0]        mag;
    logic                    neg_reg;
    logic [MUL_W-1:0]        prod_reg;
    logic [SAMPLE_W-1:0]     quot;

    assign sum_total = sum_reg + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (acc_en)
        begin
            sum_reg <= clear ? '0 : sum_total;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            total_reg <= sum_total;
        end
    end

    // Divide the magnitude, so the quotient truncates toward zero.
    assign mag = total_reg[SUM_W-1] ? SUM_W'(-total_reg) : SUM_W'(total_reg);

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            neg_reg  <= total_reg[SUM_W-1];
            prod_reg <= MUL_W'(mag) * MUL_W'(RECIP);
        end
    end

    assign quot = prod_reg[SHIFT +: SAMPLE_W];
    assign avg  = neg_reg ? -quot : quot;

endmodule

>>> src/accel_block_average_decision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_block_average_decision: block averager with a window decision
// Three-axis sample averaging over fixed blocks, a window of recent X
// averages, and a query that reports the averages and an all-entries test.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while in_ready is high and returns
// one word per word taken, in order, from its output register.
// A word passes three stages: the per-axis accumulators, a reciprocal
// multiply that divides a finished block sum by BLOCK_LEN, and a commit stage
// that updates the averages and the window and evaluates a query against all
// WINDOW_LEN window cells in parallel. Stages advance independently, so new
// words are taken while a result waits in the output register. The gain
// register may only be written while no word is in flight.
// ----------------------------------------------------------------------------
module accel_block_average_decision
    import abad_pkg::*;
#(
    parameter int BLOCK_LEN  = 20,
    parameter int WINDOW_LEN = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [GAIN_W-1:0]          cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample_x,
    input  logic signed [SAMPLE_W-1:0] sample_y,
    input  logic signed [SAMPLE_W-1:0] sample_z,
    input  logic signed [SAMPLE_W-1:0] threshold,
    input  logic                       compare_below,
    input  logic signed [SAMPLE_W-1:0] baseline,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] avg_x,
    output logic signed [SAMPLE_W-1:0] avg_y,
    output logic signed [SAMPLE_W-1:0] avg_z,
    output logic                       averages_valid,
    output logic                       block_done,
    output logic                       changed,
    output logic                       decision_met
);

    localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

    logic [GAIN_W-1:0] gain_reg;

    // Accumulate stage.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             adv1;
    logic             sample_acc;
    logic             done_in;

    // Stage one payload.
    logic                       v1_reg;
    logic                       v1_next;
    mode_t                      mode1_reg;
    logic                       done1_reg;
    logic signed [SAMPLE_W-1:0] thr1_reg;
    logic                       below1_reg;
    logic signed [SAMPLE_W-1:0] base1_reg;
    logic                       adv2;

    // Stage two payload.
    logic                       v2_reg;
    logic                       v2_next;
    mode_t                      mode2_reg;
    logic                       done2_reg;
    logic signed [BOUND_W-1:0]  bound2_reg;
    logic                       below2_reg;
    logic signed [SAMPLE_W-1:0] base2_reg;
    logic                       adv3;

    logic signed [BOUND_W-1:0]  thr_ext;
    logic signed [BOUND_W-1:0]  thr5;
    logic signed [BOUND_W-1:0]  bound;

    // Commit stage state.
    logic signed [SAMPLE_W-1:0] avg_x_reg;
    logic signed [SAMPLE_W-1:0] avg_y_reg;
    logic signed [SAMPLE_W-1:0] avg_z_reg;
    logic signed [SAMPLE_W-1:0] avg_x_next;
    logic signed [SAMPLE_W-1:0] avg_y_next;
    logic signed [SAMPLE_W-1:0] avg_z_next;
    logic                       valid_flag_reg;
    logic                       valid_flag_next;
    logic                       change_reg;
    logic                       change_next;
    logic signed [SAMPLE_W-1:0] quot_x;
    logic signed [SAMPLE_W-1:0] quot_y;
    logic signed [SAMPLE_W-1:0] quot_z;
    logic                       commit_done;
    logic                       commit_query;
    logic                       chg;
    logic                       met;

    // Output register.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_x_reg;
    logic signed [SAMPLE_W-1:0] out_y_reg;
    logic signed [SAMPLE_W-1:0] out_z_reg;
    logic                       out_avalid_reg;
    logic                       out_done_reg;
    logic                       out_chg_reg;
    logic                       out_met_reg;

    // Window cells.
    query_t     query;
    cell_link_t link [WINDOW_LEN+1];
    logic       pass_chain [WINDOW_LEN+1];
    logic       window_full;

    // ------------------------------------------------------------------
    // Handshake: each stage moves when the stage after it is empty or moving.
    // ------------------------------------------------------------------
    assign adv3     = v2_reg && (!out_valid_reg || out_ready);
    assign adv2     = v1_reg && (!v2_reg || adv3);
    assign in_ready = !v1_reg || adv2;
    assign adv1     = in_valid && in_ready;

    assign sample_acc = adv1 && (mode_t'(mode) == MODE_SAMPLE);
    assign done_in    = (count_reg == CNT_LAST);

    always_comb
    begin
        count_next = count_reg;
        if (sample_acc)
        begin
            count_next = done_in ? '0 : count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        v1_next = v1_reg;
        if (adv1)
        begin
            v1_next = 1'b1;
        end
        else if (adv2)
        begin
            v1_next = 1'b0;
        end
    end

    always_comb
    begin
        v2_next = v2_reg;
        if (adv2)
        begin
            v2_next = 1'b1;
        end
        else if (adv3)
        begin
            v2_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv3)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Per-axis accumulators and dividers.
    // ------------------------------------------------------------------
    abad_axis #(.BLOCK_LEN(BLOCK_LEN)) u_axis_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc_en (sample_acc),
        .clear  (done_in),
        .load1  (adv1),
        .load2  (adv2),
        .sample (sample_x),
        .avg    (quot_x)
    );

    abad_axis #(.BLOCK_LEN(BLOCK_LEN)) u_axis_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc_en (sample_acc),
        .clear  (done_in),
        .load1  (adv1),
        .load2  (adv2),
        .sample (sample_y),
        .avg    (quot_y)
    );

    abad_axis #(.BLOCK_LEN(BLOCK_LEN)) u_axis_z
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc_en (sample_acc),
        .clear  (done_in),
        .load1  (adv1),
        .load2  (adv2),
        .sample (sample_z),
        .avg    (quot_z)
    );

    // ------------------------------------------------------------------
    // Query bound on the product side. For trunc(p / 5) >= t the test is
    // p >= 5t when t is positive and p >= 5t - 4 otherwise; the at-most
    // test mirrors it.
    // ------------------------------------------------------------------
    assign thr_ext = BOUND_W'(thr1_reg);
    assign thr5    = (thr_ext <<< 2) + thr_ext;

    always_comb
    begin
        if (below1_reg)
        begin
            bound = thr_ext[BOUND_W-1] ? thr5 : thr5 + BOUND_W'(4);
        end
        else
        begin
            bound = (thr_ext > 0) ? thr5 : thr5 - BOUND_W'(4);
        end
    end

    // ------------------------------------------------------------------
    // Commit stage.
    // ------------------------------------------------------------------
    assign commit_done  = adv3 && (mode2_reg == MODE_SAMPLE) && done2_reg;
    assign commit_query = adv3 && (mode2_reg == MODE_QUERY);

    assign avg_x_next      = commit_done ? quot_x : avg_x_reg;
    assign avg_y_next      = commit_done ? quot_y : avg_y_reg;
    assign avg_z_next      = commit_done ? quot_z : avg_z_reg;
    assign valid_flag_next = valid_flag_reg | commit_done;

    assign chg = (mode2_reg == MODE_QUERY) && valid_flag_reg && change_reg;
    assign met = (mode2_reg == MODE_QUERY) && window_full && pass_chain[WINDOW_LEN];

    always_comb
    begin
        change_next = change_reg;
        if (commit_done)
        begin
            change_next = 1'b1;
        end
        else if (commit_query)
        begin
            change_next = 1'b0;
        end
    end

    assign query = '{baseline: base2_reg, gain: gain_reg, bound: bound2_reg,
                     below: below2_reg};

    assign link[0]       = '{valid: 1'b1, entry: quot_x};
    assign pass_chain[0] = 1'b1;

    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        abad_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (commit_done),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .query    (query),
            .pass_in  (pass_chain[i]),
            .pass_out (pass_chain[i+1])
        );
    end

    // The last cell holds a valid entry once the window has filled.
    assign window_full = link[WINDOW_LEN].valid;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= '0;
            count_reg      <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            avg_x_reg      <= '0;
            avg_y_reg      <= '0;
            avg_z_reg      <= '0;
            valid_flag_reg <= 1'b0;
            change_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_wdata;
            end
            count_reg      <= count_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            out_valid_reg  <= out_valid_next;
            avg_x_reg      <= avg_x_next;
            avg_y_reg      <= avg_y_next;
            avg_z_reg      <= avg_z_next;
            valid_flag_reg <= valid_flag_next;
            change_reg     <= change_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            mode1_reg  <= mode_t'(mode);
            done1_reg  <= done_in;
            thr1_reg   <= threshold;
            below1_reg <= compare_below;
            base1_reg  <= baseline;
        end
        if (adv2)
        begin
            mode2_reg  <= mode1_reg;
            done2_reg  <= done1_reg;
            bound2_reg <= bound;
            below2_reg <= below1_reg;
            base2_reg  <= base1_reg;
        end
        if (adv3)
        begin
            out_x_reg      <= avg_x_next;
            out_y_reg      <= avg_y_next;
            out_z_reg      <= avg_z_next;
            out_avalid_reg <= valid_flag_next;
            out_done_reg   <= commit_done;
            out_chg_reg    <= chg;
            out_met_reg    <= met;
        end
    end

    assign out_valid      = out_valid_reg;
    assign avg_x          = out_x_reg;
    assign avg_y          = out_y_reg;
    assign avg_z          = out_z_reg;
    assign averages_valid = out_avalid_reg;
    assign block_done     = out_done_reg;
    assign changed        = out_chg_reg;
    assign decision_met   = out_met_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_done |-> !changed && !decision_met)
        else $error("block_done word also reports query fields");

    a_met_needs_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (decision_met || changed) |-> averages_valid)
        else $error("query reports a decision or change before any average");

    a_full_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        window_full |-> valid_flag_reg)
        else $error("window full before any block completed");

    a_change_set: assert property (@(posedge clk) disable iff (!rst_n)
        commit_done |=> change_reg && valid_flag_reg)
        else $error("completed block did not raise the change and valid flags");

endmodule

>>> tb/sv/block_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_checker: result predictor and comparator
// Watches the gain port and both word channels of the block averager. It
// keeps its own copy of the accumulators, averages and decision window,
// queues the expected report for every accepted word and compares each
// returned word with the oldest one.
// ----------------------------------------------------------------------------
module block_average_checker
    import abad_pkg::*;
#(
    parameter int BLOCK_LEN  = 20,
    parameter int WINDOW_LEN = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [GAIN_W-1:0]          cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample_x,
    input  logic signed [SAMPLE_W-1:0] sample_y,
    input  logic signed [SAMPLE_W-1:0] sample_z,
    input  logic signed [SAMPLE_W-1:0] threshold,
    input  logic                       compare_below,
    input  logic signed [SAMPLE_W-1:0] baseline,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] avg_x,
    input  logic signed [SAMPLE_W-1:0] avg_y,
    input  logic signed [SAMPLE_W-1:0] avg_z,
    input  logic                       averages_valid,
    input  logic                       block_done,
    input  logic                       changed,
    input  logic                       decision_met,
    output int                         outstanding,
    output int                         failures
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic                       have_avg;
        logic                       done;
        logic                       chg;
        logic                       met;
    } avg_report_t;

    logic [GAIN_W-1:0]          gain_reg;
    int                         acc_x;
    int                         acc_y;
    int                         acc_z;
    int                         acc_count;
    logic signed [SAMPLE_W-1:0] avg_reg [3];
    logic                       avg_ready;
    logic                       news_pending;
    logic signed [SAMPLE_W-1:0] hist [WINDOW_LEN];
    int                         hist_ptr;
    logic                       hist_full;
    avg_report_t                due_reports [$];
    int                         mismatches;

    // True only when the window has wrapped at least once and every entry
    // lies on the requested side of the threshold after scaling.
    function automatic logic window_holds(
        input logic signed [SAMPLE_W-1:0] thr,
        input logic                       below,
        input logic signed [SAMPLE_W-1:0] base
    );
        int scaled;
        int i;
        if (!hist_full)
            return 1'b0;
        for (i = 0; i < WINDOW_LEN; i++)
        begin
            scaled = ((int'(hist[i]) - int'(base)) * (2 * int'(gain_reg))) / 10;
            if (below ? (scaled > int'(thr)) : (scaled < int'(thr)))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic avg_report_t advance_averager(
        input mode_t                      m,
        input logic signed [SAMPLE_W-1:0] sx,
        input logic signed [SAMPLE_W-1:0] sy,
        input logic signed [SAMPLE_W-1:0] sz,
        input logic signed [SAMPLE_W-1:0] thr,
        input logic                       below,
        input logic signed [SAMPLE_W-1:0] base
    );
        avg_report_t r;
        r.done = 1'b0;
        r.chg  = 1'b0;
        r.met  = 1'b0;
        if (m == MODE_SAMPLE)
        begin
            acc_x += int'(sx);
            acc_y += int'(sy);
            acc_z += int'(sz);
            acc_count++;
            if (acc_count >= BLOCK_LEN)
            begin
                // Integer division of int truncates toward zero.
                avg_reg[0]   = SAMPLE_W'(acc_x / BLOCK_LEN);
                avg_reg[1]   = SAMPLE_W'(acc_y / BLOCK_LEN);
                avg_reg[2]   = SAMPLE_W'(acc_z / BLOCK_LEN);
                acc_x        = 0;
                acc_y        = 0;
                acc_z        = 0;
                acc_count    = 0;
                avg_ready    = 1'b1;
                news_pending = 1'b1;
                r.done       = 1'b1;
                if (hist_ptr >= WINDOW_LEN)
                    hist_ptr = 0;
                hist[hist_ptr] = avg_reg[0];
                hist_ptr++;
                if (hist_ptr >= WINDOW_LEN)
                begin
                    hist_ptr  = 0;
                    hist_full = 1'b1;
                end
            end
        end
        else
        begin
            r.chg = avg_ready && news_pending;
            if (avg_ready)
                news_pending = 1'b0;
            r.met = window_holds(thr, below, base);
        end
        r.ax       = avg_reg[0];
        r.ay       = avg_reg[1];
        r.az       = avg_reg[2];
        r.have_avg = avg_ready;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_report_t want;
        int          i;
        if (!rst_n)
        begin
            gain_reg     = '0;
            acc_x        = 0;
            acc_y        = 0;
            acc_z        = 0;
            acc_count    = 0;
            avg_ready    = 1'b0;
            news_pending = 1'b0;
            hist_ptr     = 0;
            hist_full    = 1'b0;
            for (i = 0; i < 3; i++)
                avg_reg[i] = '0;
            for (i = 0; i < WINDOW_LEN; i++)
                hist[i] = '0;
            due_reports.delete();
            mismatches   = 0;
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (cfg_we)
                gain_reg = cfg_wdata;
            if (in_valid && in_ready)
                due_reports.push_back(advance_averager(mode_t'(mode), sample_x, sample_y,
                    sample_z, threshold, compare_below, baseline));
            if (out_valid && out_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: word at %0t with no report due", $time);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (avg_x !== want.ax || avg_y !== want.ay || avg_z !== want.az ||
                        averages_valid !== want.have_avg || block_done !== want.done ||
                        changed !== want.chg || decision_met !== want.met)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("checker: mismatch at %0t", $time);
                            $display("  expected avg %0d %0d %0d valid %0b done %0b changed %0b met %0b",
                                want.ax, want.ay, want.az, want.have_avg, want.done,
                                want.chg, want.met);
                            $display("  got      avg %0d %0d %0d valid %0b done %0b changed %0b met %0b",
                                avg_x, avg_y, avg_z, averages_valid, block_done,
                                changed, decision_met);
                        end
                    end
                end
            end
            outstanding <= due_reports.size();
            failures    <= mismatches;
        end
    end

endmodule

>>> tb/sv/tb_accel_block_average_decision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_block_average_decision: stimulus and verdict for the averager
// Drives a short directed sequence and then segments of random samples and
// queries, built around a slowly moving level so that whole blocks, a full
// window and both decision outcomes are reached. Gain changes between
// segments; flow control on both channels varies per segment.
// ----------------------------------------------------------------------------
module tb_accel_block_average_decision
    import abad_pkg::*;
();

    localparam int BLOCK_LEN  = 20;
    localparam int WINDOW_LEN = 5;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [GAIN_W-1:0]          cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
    logic signed [SAMPLE_W-1:0] threshold;
    logic                       compare_below;
    logic signed [SAMPLE_W-1:0] baseline;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] avg_x;
    logic signed [SAMPLE_W-1:0] avg_y;
    logic signed [SAMPLE_W-1:0] avg_z;
    logic                       averages_valid;
    logic                       block_done;
    logic                       changed;
    logic                       decision_met;
    int                         outstanding;
    int                         failures;

    int gap_pct   = 34;
    int stall_pct = 63;
    int cur_gain  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    accel_block_average_decision #(
        .BLOCK_LEN  (BLOCK_LEN),
        .WINDOW_LEN (WINDOW_LEN)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .sample_x       (sample_x),
        .sample_y       (sample_y),
        .sample_z       (sample_z),
        .threshold      (threshold),
        .compare_below  (compare_below),
        .baseline       (baseline),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .avg_x          (avg_x),
        .avg_y          (avg_y),
        .avg_z          (avg_z),
        .averages_valid (averages_valid),
        .block_done     (block_done),
        .changed        (changed),
        .decision_met   (decision_met)
    );

    block_average_checker #(
        .BLOCK_LEN  (BLOCK_LEN),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .sample_x       (sample_x),
        .sample_y       (sample_y),
        .sample_z       (sample_z),
        .threshold      (threshold),
        .compare_below  (compare_below),
        .baseline       (baseline),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .avg_x          (avg_x),
        .avg_y          (avg_y),
        .avg_z          (avg_z),
        .averages_valid (averages_valid),
        .block_done     (block_done),
        .changed        (changed),
        .decision_met   (decision_met),
        .outstanding    (outstanding),
        .failures       (failures)
    );

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input int v);
        if (v > 32767)
            return S_MAX;
        if (v < -32768)
            return S_MIN;
        return SAMPLE_W'(v);
    endfunction

    function automatic int pick_level();
        case ($urandom_range(3))
            0:       return span(-32768, 32767);
            1:       return $urandom_range(1) ? 32767 : -32768;
            2:       return span(-200, 200);
            default: return span(-3000, 3000);
        endcase
    endfunction

    function automatic int pick_spread();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 40;
            default: return 2000;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] axis_value(input int lvl, input int spread);
        if ($urandom_range(99) < 8)
            return SAMPLE_W'($urandom);
        return sat16(lvl + span(-spread, spread));
    endfunction

    // Called just after a rising edge; returns at the edge that takes the word.
    task automatic send_word(
        input mode_t                      m,
        input logic signed [SAMPLE_W-1:0] sx,
        input logic signed [SAMPLE_W-1:0] sy,
        input logic signed [SAMPLE_W-1:0] sz,
        input logic signed [SAMPLE_W-1:0] thr,
        input logic                       below,
        input logic signed [SAMPLE_W-1:0] base
    );
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        sample_x      <= sx;
        sample_y      <= sy;
        sample_z      <= sz;
        threshold     <= thr;
        compare_below <= below;
        baseline      <= base;
        // Ready is settled by the falling edge and holds until the next rise.
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gain(input int g);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= GAIN_W'(g);
        cur_gain   = g;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Samples follow a level that moves now and then, so block averages and
    // window entries cluster; most queries aim the threshold near the scaled
    // level so that the decision lands on both sides.
    task automatic run_segment(input int n);
        int   lvl;
        int   spread;
        int   base;
        int   thr;
        int   k;
        logic below;
        lvl    = pick_level();
        spread = pick_spread();
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 4)
            begin
                lvl    = pick_level();
                spread = pick_spread();
            end
            if ($urandom_range(99) < 12)
            begin
                below = 1'($urandom_range(1));
                if ($urandom_range(99) < 25)
                begin
                    base = span(-32768, 32767);
                    thr  = span(-32768, 32767);
                end
                else
                begin
                    base = sat16(lvl + span(-100, 100));
                    thr  = ((lvl - base) * 2 * cur_gain) / 10 + span(-12, 12);
                end
                send_word(MODE_QUERY, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                    SAMPLE_W'($urandom), sat16(thr), below, sat16(base));
            end
            else
                send_word(MODE_SAMPLE, axis_value(lvl, spread), axis_value(lvl, spread),
                    axis_value(lvl, spread), SAMPLE_W'($urandom), 1'($urandom),
                    SAMPLE_W'($urandom));
        end
    endtask

    initial
    begin
        int k;
        int seg;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        mode          = MODE_SAMPLE;
        sample_x      = '0;
        sample_y      = '0;
        sample_z      = '0;
        threshold     = '0;
        compare_below = 1'b0;
        baseline      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_gain(255);
        // Query before any block: nothing valid, no change, no decision.
        send_word(MODE_QUERY, S_MAX, S_MIN, S_MAX, S_MAX, 1'b1, S_MIN);
        // One block at the extremes; Z averages to -0.5, which truncates to 0.
        for (k = 0; k < BLOCK_LEN; k++)
            send_word(MODE_SAMPLE, S_MAX, S_MIN, (k % 2) ? S_MIN : S_MAX, S_MIN, 1'b1, S_MAX);
        // The first query reports the change, the second finds it cleared;
        // the window is not full yet, so no decision either way.
        send_word(MODE_QUERY, '0, '0, '0, S_MIN, 1'b0, S_MAX);
        send_word(MODE_QUERY, S_MIN, S_MAX, S_MIN, S_MIN, 1'b0, S_MIN);
        send_word(MODE_SAMPLE, '0, '0, '0, '0, 1'b0, '0);

        for (seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    gap_pct    = 34;
                    stall_pct <= 63;
                end
                1:
                begin
                    gap_pct    = 63;
                    stall_pct <= 34;
                end
                default:
                begin
                    gap_pct    = 0;
                    stall_pct <= 0;
                end
            endcase
            case (seg)
                0:       write_gain(0);
                1:       write_gain($urandom_range(255));
                2:       write_gain(1);
                3:       write_gain(255);
                4:       write_gain($urandom_range(255));
                default: write_gain(10);
            endcase
            run_segment(50);
            // Hold the sender off mid-segment until every word has come back.
            if (seg == 3)
                settle();
            run_segment(50);
        end

        settle();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout set far beyond the length of a correct run.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/abad_pkg.sv
src/abad_cell.sv
src/abad_axis.sv
src/accel_block_average_decision.sv
tb/sv/block_average_checker.sv
tb/sv/tb_accel_block_average_decision.sv
